/* src/first_fit_extent_allocator_unit_defines.svh */
// assertion macros for the first fit extent allocator
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define FFEA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffea assertion failed");
`define FFEA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffea assertion failed");
`else
`define FFEA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define FFEA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* src/ffea_pkg.sv */
`timescale 1ns / 1ps
package ffea_pkg;

   localparam int PAGE_W       = 52;
   localparam int SIZE_W       = 53;
   localparam int SUM_W        = 54;
   localparam int FFEA_ENTRIES = 64;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_RESV  = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NOFIT    = 2'd1;
   localparam logic [1:0] STS_NOTFOUND = 2'd2;
   localparam logic [1:0] STS_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]        action;
      logic [PAGE_W-1:0] page;
      logic [PAGE_W-1:0] pages;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] result_page;
   } rsp_type;

   // one table entry against the current request
   typedef struct packed {
      logic [PAGE_W-1:0] base;
      logic [SIZE_W-1:0] size;
      logic [PAGE_W-1:0] page;
      logic [PAGE_W-1:0] pages;
      logic [SIZE_W-1:0] req_end;
      logic [SIZE_W-1:0] ins_page;
      logic [SIZE_W-1:0] ins_pages;
      logic [SUM_W-1:0]  ins_end;
   } match_in_type;

   typedef struct packed {
      logic              fit;
      logic              contain;
      logic              empty;
      logic              merge_lo;
      logic              merge_hi;
      logic [SUM_W-1:0]  end_sum;
      logic [PAGE_W-1:0] alloc_base;
      logic [SIZE_W-1:0] alloc_size;
      logic [SIZE_W-1:0] grow_size;
      logic [SIZE_W-1:0] front_size;
      logic [SIZE_W-1:0] back_size;
   } match_type;

endpackage

/* src/ffea_store.sv */
`timescale 1ns / 1ps
module ffea_store #(
   parameter int ENTRIES = ffea_pkg::FFEA_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(ENTRIES)-1:0]      rd_addr,
   output logic [ffea_pkg::PAGE_W-1:0]     rd_base,
   output logic [ffea_pkg::SIZE_W-1:0]     rd_size,
   input  logic                            wr_en,
   input  logic [$clog2(ENTRIES)-1:0]      wr_addr,
   input  logic [ffea_pkg::PAGE_W-1:0]     wr_base,
   input  logic [ffea_pkg::SIZE_W-1:0]     wr_size
);
   import ffea_pkg::*;

   localparam int IW = $clog2(ENTRIES);

   logic [PAGE_W-1:0] base_mem [ENTRIES];
   logic [SIZE_W-1:0] size_mem [ENTRIES];
   logic [PAGE_W-1:0] rd_base_ff;
   logic [SIZE_W-1:0] rd_size_ff;
   logic              zero_set_ff;
   logic              zero_set_in;
   logic              rd_zero_ff;
   logic              rd_zero_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         base_mem[wr_addr] <= wr_base;
         size_mem[wr_addr] <= wr_size;
      end
      rd_base_ff <= base_mem[rd_addr];
      rd_size_ff <= size_mem[rd_addr];
   end

   // entry zero reads as an empty extent at page zero until first written
   assign zero_set_in = zero_set_ff | (wr_en & (wr_addr == IW'(0)));
   assign rd_zero_in  = (rd_addr == IW'(0)) & ~zero_set_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_set_ff <= 1'b0;
         rd_zero_ff  <= 1'b0;
      end else begin
         zero_set_ff <= zero_set_in;
         rd_zero_ff  <= rd_zero_in;
      end
   end

   assign rd_base = rd_zero_ff ? '0 : rd_base_ff;
   assign rd_size = rd_zero_ff ? '0 : rd_size_ff;

endmodule

/* src/ffea_match.sv */
`timescale 1ns / 1ps
module ffea_match (
   input  ffea_pkg::match_in_type mi,
   output ffea_pkg::match_type    mo
);
   import ffea_pkg::*;

   logic [SUM_W-1:0] end_sum;

   assign end_sum = SUM_W'(mi.base) + SUM_W'(mi.size);

   always_comb begin
      mo.end_sum    = end_sum;
      mo.fit        = mi.size >= SIZE_W'(mi.pages);
      mo.contain    = (mi.page >= mi.base) && (SUM_W'(mi.req_end) <= end_sum);
      mo.empty      = mi.size == '0;
      mo.merge_lo   = SUM_W'(mi.base) == mi.ins_end;
      mo.merge_hi   = SUM_W'(mi.ins_page) == end_sum;
      mo.alloc_base = mi.base + mi.pages;
      mo.alloc_size = mi.size - SIZE_W'(mi.pages);
      mo.grow_size  = mi.size + mi.ins_pages;
      mo.front_size = SIZE_W'(mi.page - mi.base);
      mo.back_size  = SIZE_W'(end_sum - SUM_W'(mi.req_end));
   end

endmodule

/* src/first_fit_extent_allocator_unit.sv */
// first fit extent allocator over a 52-bit page space
// request channel (req_valid / req_stall / req_data): one beat carries an action
// (allocate, free, reserve), a base page and a page count
// response channel (rsp_valid / rsp_stall / rsp_data): one beat per request with
// a status and, for a successful allocate, the page handed out
// the free-extent table sits in a memory with one read and one write port; the
// sequencer walks it in order, one entry per cycle, through one shared compare / add
// unit; a request walks up to the n table entries in use (at most ENTRIES), and a
// reserve that leaves a tail walks the table twice
// a request is taken only while the sequencer is idle, so a new request waits until
// the previous one has handed its reply to the output register
// a finished response waits in an output register: a stalled receiver does not
// stop the next request from being taken, only its reply waits for the slot
// reset empties the table to one empty extent at page zero and drops any
// pending response
`timescale 1ns / 1ps
`include "first_fit_extent_allocator_unit_defines.svh"
module first_fit_extent_allocator_unit #(
   parameter int ENTRIES = ffea_pkg::FFEA_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffea_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffea_pkg::rsp_type rsp_data
);
   import ffea_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_WHOLD = 3'd4;
   localparam logic [2:0] S_REPLY = 3'd5;

   // what the walk is looking for
   localparam logic [1:0] MD_ALLOC = 2'd0;
   localparam logic [1:0] MD_RESV  = 2'd1;
   localparam logic [1:0] MD_INS   = 2'd2;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        mode_ff, mode_in;
   logic [1:0]        act_ff, act_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [PAGE_W-1:0] pages_ff, pages_in;
   logic [SIZE_W-1:0] req_end_ff, req_end_in;
   logic [CW-1:0]     count_ff, count_in;

   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic              chk_valid_ff, chk_valid_in;
   logic              chk_last_ff, chk_last_in;
   logic [IW-1:0]     chk_idx_ff, chk_idx_in;

   logic              have_empty_ff, have_empty_in;
   logic [IW-1:0]     empty_at_ff, empty_at_in;

   logic [SIZE_W-1:0] ins_page_ff, ins_page_in;
   logic [SIZE_W-1:0] ins_pages_ff, ins_pages_in;
   logic [SUM_W-1:0]  ins_end_ff, ins_end_in;

   // reserve keeps the shrunk front extent aside until its tail is placed
   logic              hold_act_ff, hold_act_in;
   logic [IW-1:0]     hold_idx_ff, hold_idx_in;
   logic [PAGE_W-1:0] hold_base_ff, hold_base_in;
   logic [SIZE_W-1:0] hold_size_ff, hold_size_in;

   logic [IW-1:0]     pri_idx_ff, pri_idx_in;
   logic [PAGE_W-1:0] pri_base_ff, pri_base_in;
   logic [SIZE_W-1:0] pri_size_ff, pri_size_in;
   logic              pri_append_ff, pri_append_in;

   logic [1:0]        stat_ff, stat_in;
   logic [PAGE_W-1:0] result_ff, result_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              rsp_free;
   logic              issue;
   logic [IW-1:0]     rd_addr;
   logic [PAGE_W-1:0] st_base;
   logic [SIZE_W-1:0] st_size;
   logic [SIZE_W-1:0] ent_size;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [PAGE_W-1:0] wr_base;
   logic [SIZE_W-1:0] wr_size;
   match_in_type      m_in;
   match_type         m;

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign issue   = (state_ff == S_SCAN) && (rd_idx_ff < count_ff);
   assign rd_addr = rd_idx_ff[IW-1:0];

   // write port: primary update first, then the held front extent
   assign wr_en   = (state_ff == S_WRITE) || (state_ff == S_WHOLD);
   assign wr_addr = (state_ff == S_WRITE) ? pri_idx_ff : hold_idx_ff;
   assign wr_base = (state_ff == S_WRITE) ? pri_base_ff : hold_base_ff;
   assign wr_size = (state_ff == S_WRITE) ? pri_size_ff : hold_size_ff;

   ffea_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_base (st_base),
      .rd_size (st_size),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_base (wr_base),
      .wr_size (wr_size)
   );

   // the held entry is seen with its shrunk size during the tail walk
   assign ent_size = (hold_act_ff && (chk_idx_ff == hold_idx_ff)) ? hold_size_ff : st_size;

   always_comb begin
      m_in.base      = st_base;
      m_in.size      = ent_size;
      m_in.page      = page_ff;
      m_in.pages     = pages_ff;
      m_in.req_end   = req_end_ff;
      m_in.ins_page  = ins_page_ff;
      m_in.ins_pages = ins_pages_ff;
      m_in.ins_end   = ins_end_ff;
   end

   ffea_match u_match (
      .mi (m_in),
      .mo (m)
   );

   always_comb begin
      logic          first_empty;
      logic          found_empty;
      logic [IW-1:0] empty_idx;

      state_in      = state_ff;
      mode_in       = mode_ff;
      act_in        = act_ff;
      page_in       = page_ff;
      pages_in      = pages_ff;
      req_end_in    = req_end_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      chk_valid_in  = 1'b0;
      chk_last_in   = chk_last_ff;
      chk_idx_in    = chk_idx_ff;
      have_empty_in = have_empty_ff;
      empty_at_in   = empty_at_ff;
      ins_page_in   = ins_page_ff;
      ins_pages_in  = ins_pages_ff;
      ins_end_in    = ins_end_ff;
      hold_act_in   = hold_act_ff;
      hold_idx_in   = hold_idx_ff;
      hold_base_in  = hold_base_ff;
      hold_size_in  = hold_size_ff;
      pri_idx_in    = pri_idx_ff;
      pri_base_in   = pri_base_ff;
      pri_size_in   = pri_size_ff;
      pri_append_in = pri_append_ff;
      stat_in       = stat_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;

      first_empty = ~have_empty_ff & m.empty;
      found_empty = have_empty_ff | first_empty;
      empty_idx   = have_empty_ff ? empty_at_ff : chk_idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               act_in     = req_data.action;
               page_in    = req_data.page;
               pages_in   = req_data.pages;
               req_end_in = SIZE_W'(req_data.page) + SIZE_W'(req_data.pages);
               state_in   = S_START;
            end
         end
         S_START: begin
            stat_in       = STS_OK;
            result_in     = '0;
            hold_act_in   = 1'b0;
            rd_idx_in     = '0;
            have_empty_in = 1'b0;
            pri_append_in = 1'b0;
            if (pages_ff == '0) begin
               state_in = S_REPLY;
            end else begin
               case (act_ff)
                  ACT_ALLOC: begin
                     mode_in  = MD_ALLOC;
                     state_in = S_SCAN;
                  end
                  ACT_FREE: begin
                     // region running past the top of the page space
                     if (req_end_ff[SIZE_W-1] && (req_end_ff[PAGE_W-1:0] != '0)) begin
                        stat_in  = STS_NOTFOUND;
                        state_in = S_REPLY;
                     end else begin
                        mode_in      = MD_INS;
                        ins_page_in  = SIZE_W'(page_ff);
                        ins_pages_in = SIZE_W'(pages_ff);
                        ins_end_in   = SUM_W'(req_end_ff);
                        state_in     = S_SCAN;
                     end
                  end
                  ACT_RESV: begin
                     mode_in  = MD_RESV;
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_REPLY;
                  end
               endcase
            end
         end
         S_SCAN: begin
            chk_valid_in = issue;
            chk_idx_in   = rd_addr;
            chk_last_in  = rd_idx_ff == (count_ff - CW'(1));
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (chk_valid_ff) begin
               case (mode_ff)
                  MD_ALLOC: begin
                     if (m.fit) begin
                        pri_idx_in  = chk_idx_ff;
                        pri_base_in = m.alloc_base;
                        pri_size_in = m.alloc_size;
                        result_in   = st_base;
                        stat_in     = STS_OK;
                        state_in    = S_WRITE;
                     end else if (chk_last_ff) begin
                        stat_in  = STS_NOFIT;
                        state_in = S_REPLY;
                     end
                  end
                  MD_RESV: begin
                     if (m.contain) begin
                        hold_idx_in  = chk_idx_ff;
                        hold_base_in = st_base;
                        hold_size_in = m.front_size;
                        stat_in      = STS_OK;
                        if (m.back_size == '0) begin
                           pri_idx_in  = chk_idx_ff;
                           pri_base_in = st_base;
                           pri_size_in = m.front_size;
                           state_in    = S_WRITE;
                        end else begin
                           // walk again to place the tail behind the region
                           mode_in       = MD_INS;
                           ins_page_in   = req_end_ff;
                           ins_pages_in  = m.back_size;
                           ins_end_in    = m.end_sum;
                           hold_act_in   = 1'b1;
                           rd_idx_in     = '0;
                           chk_valid_in  = 1'b0;
                           have_empty_in = 1'b0;
                        end
                     end else if (chk_last_ff) begin
                        stat_in  = STS_NOTFOUND;
                        state_in = S_REPLY;
                     end
                  end
                  MD_INS: begin
                     if (first_empty) begin
                        have_empty_in = 1'b1;
                        empty_at_in   = chk_idx_ff;
                     end
                     if (!first_empty && m.merge_lo) begin
                        pri_idx_in  = chk_idx_ff;
                        pri_base_in = ins_page_ff[PAGE_W-1:0];
                        pri_size_in = m.grow_size;
                        stat_in     = STS_OK;
                        state_in    = S_WRITE;
                     end else if (!first_empty && m.merge_hi) begin
                        pri_idx_in  = chk_idx_ff;
                        pri_base_in = st_base;
                        pri_size_in = m.grow_size;
                        stat_in     = STS_OK;
                        state_in    = S_WRITE;
                     end else if (chk_last_ff) begin
                        pri_base_in = ins_page_ff[PAGE_W-1:0];
                        pri_size_in = ins_pages_ff;
                        stat_in     = STS_OK;
                        if (found_empty) begin
                           pri_idx_in = empty_idx;
                           state_in   = S_WRITE;
                        end else if (count_ff >= CW'(ENTRIES)) begin
                           // table full: nothing is written, front extent stays whole
                           stat_in  = STS_FULL;
                           state_in = S_REPLY;
                        end else begin
                           pri_idx_in    = count_ff[IW-1:0];
                           pri_append_in = 1'b1;
                           state_in      = S_WRITE;
                        end
                     end
                  end
                  default: begin
                     state_in = S_REPLY;
                  end
               endcase
            end
         end
         S_WRITE: begin
            if (pri_append_ff) begin
               count_in = count_ff + CW'(1);
            end
            if (hold_act_ff && (hold_idx_ff != pri_idx_ff)) begin
               state_in = S_WHOLD;
            end else begin
               state_in = S_REPLY;
            end
         end
         S_WHOLD: begin
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = stat_ff;
               rsp_data_in.result_page = result_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= CW'(1);
         chk_valid_ff  <= 1'b0;
         have_empty_ff <= 1'b0;
         hold_act_ff   <= 1'b0;
         pri_append_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         chk_valid_ff  <= chk_valid_in;
         have_empty_ff <= have_empty_in;
         hold_act_ff   <= hold_act_in;
         pri_append_ff <= pri_append_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      act_ff       <= act_in;
      page_ff      <= page_in;
      pages_ff     <= pages_in;
      req_end_ff   <= req_end_in;
      rd_idx_ff    <= rd_idx_in;
      chk_last_ff  <= chk_last_in;
      chk_idx_ff   <= chk_idx_in;
      empty_at_ff  <= empty_at_in;
      ins_page_ff  <= ins_page_in;
      ins_pages_ff <= ins_pages_in;
      ins_end_ff   <= ins_end_in;
      hold_idx_ff  <= hold_idx_in;
      hold_base_ff <= hold_base_in;
      hold_size_ff <= hold_size_in;
      pri_idx_ff   <= pri_idx_in;
      pri_base_ff  <= pri_base_in;
      pri_size_ff  <= pri_size_in;
      stat_ff      <= stat_in;
      result_ff    <= result_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `FFEA_ASSERT_NOW(count_in_range_a, clock, reset, 1'b1,
                    (count_ff != '0) && (count_ff <= CW'(ENTRIES)))
   `FFEA_ASSERT_NOW(check_below_count_a, clock, reset, (state_ff == S_SCAN) && chk_valid_ff,
                    CW'(chk_idx_ff) < count_ff)
   `FFEA_ASSERT_NEXT(count_only_on_write_a, clock, reset, state_ff != S_WRITE, $stable(count_ff))
   `FFEA_ASSERT_NOW(page_only_when_ok_a, clock, reset, rsp_valid_ff,
                    (rsp_data_ff.status == STS_OK) || (rsp_data_ff.result_page == '0))

endmodule

/* dv/first_fit_extent_allocator_unit_tb.sv */
`timescale 1ns / 1ps
module first_fit_extent_allocator_unit_tb;
   import ffea_pkg::*;

   // nothing accepted on either channel for this long means the block hung;
   // the slowest legal gap is a reserve with a tail, a double table walk, plus stalls
   localparam int WATCHDOG_LIMIT = 2000;
   // quiet cycles after the last reply, covers a double table walk
   localparam int DRAIN_CYCLES = 160;
   localparam logic [SUM_W-1:0] SPACE_END = SUM_W'(1) << PAGE_W;
   localparam logic [PAGE_W-1:0] TOP_PAGE = {PAGE_W{1'b1}};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   first_fit_extent_allocator_unit #(
      .ENTRIES(FFEA_ENTRIES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // shadow copy of the free-extent table, updated as each request beat is taken
   logic [PAGE_W-1:0] ext_base [FFEA_ENTRIES];
   logic [SIZE_W-1:0] ext_size [FFEA_ENTRIES];
   int unsigned       ext_count;

   rsp_type           reply_q[$];      // replies still owed by the block, oldest first
   logic [PAGE_W-1:0] held_page[$];    // regions handed out by allocate, not yet freed
   logic [PAGE_W-1:0] held_len[$];

   bit idling = 1'b0;                  // random gaps and stalls on both channels
   int fault_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int by_status[4] = '{default: 0};
   int idle_cycles = 0;
   int stall_left = 0;

   // put a free region into the table: merge into the first extent it abuts,
   // else fill the first empty slot, else append; 0 when no slot is left
   function automatic bit place_region(input logic [SUM_W-1:0] page,
                                       input logic [SUM_W-1:0] pages);
      int unsigned      hole;
      bit               have_hole;
      logic [SUM_W-1:0] top;
      hole = 0;
      have_hole = 1'b0;
      top = page + pages;
      for (int i = 0; i < ext_count; i++) begin
         // only the first empty slot is passed over, later ones can still merge
         if (!have_hole && ext_size[i] == 0) begin
            have_hole = 1'b1;
            hole = i;
         end else if (SUM_W'(ext_base[i]) == top) begin
            ext_base[i] = page[PAGE_W-1:0];
            ext_size[i] = ext_size[i] + pages[SIZE_W-1:0];
            return 1'b1;
         end else if (page == SUM_W'(ext_base[i]) + SUM_W'(ext_size[i])) begin
            ext_size[i] = ext_size[i] + pages[SIZE_W-1:0];
            return 1'b1;
         end
      end
      if (!have_hole) begin
         if (ext_count >= FFEA_ENTRIES) return 1'b0;
         hole = ext_count;
         ext_count++;
      end
      ext_base[hole] = page[PAGE_W-1:0];
      ext_size[hole] = pages[SIZE_W-1:0];
      return 1'b1;
   endfunction

   // reply the block owes for one request, table updated on the way
   function automatic rsp_type allocator_reply(input req_type item);
      rsp_type          reply;
      logic [SUM_W-1:0] page, pages, lo, hi, tail;
      logic [SIZE_W-1:0] kept;
      bit               done;
      reply.status = STS_OK;
      reply.result_page = '0;
      page = SUM_W'(item.page);
      pages = SUM_W'(item.pages);
      done = 1'b0;
      // zero length or the unused code: ok, nothing moves
      if (pages != 0) begin
         case (item.action)
            ACT_ALLOC: begin
               reply.status = STS_NOFIT;
               for (int i = 0; i < ext_count && !done; i++) begin
                  if (SUM_W'(ext_size[i]) >= pages) begin
                     // carve from the front; an extent ending at the top wraps to 0
                     reply.result_page = ext_base[i];
                     ext_base[i] = ext_base[i] + pages[PAGE_W-1:0];
                     ext_size[i] = ext_size[i] - pages[SIZE_W-1:0];
                     reply.status = STS_OK;
                     done = 1'b1;
                  end
               end
            end
            ACT_FREE: begin
               if (page + pages > SPACE_END) reply.status = STS_NOTFOUND;
               else if (!place_region(page, pages)) reply.status = STS_FULL;
            end
            ACT_RESV: begin
               reply.status = STS_NOTFOUND;
               for (int i = 0; i < ext_count && !done; i++) begin
                  lo = SUM_W'(ext_base[i]);
                  hi = lo + SUM_W'(ext_size[i]);
                  if (page >= lo && page + pages <= hi) begin
                     // keep the front, place the back part like a freed region;
                     // with no slot left the split is undone
                     kept = ext_size[i];
                     tail = hi - (page + pages);
                     ext_size[i] = SIZE_W'(page - lo);
                     reply.status = STS_OK;
                     if (tail != 0 && !place_region(page + pages, tail)) begin
                        ext_size[i] = kept;
                        reply.status = STS_FULL;
                     end
                     done = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      return reply;
   endfunction

   function automatic logic [PAGE_W-1:0] any_page();
      return PAGE_W'({$urandom, $urandom});
   endfunction

   // one request beat; the expected reply is worked out at the edge it is taken
   task automatic send_request(input logic [1:0] action, input logic [PAGE_W-1:0] page,
                               input logic [PAGE_W-1:0] pages, output rsp_type reply);
      req_type item;
      item.action = action;
      item.page = page;
      item.pages = pages;
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      reply = allocator_reply(item);
      reply_q.push_back(reply);
      by_status[reply.status]++;
      sent_count++;
   endtask

   task automatic log_fault(input string what, input logic [PAGE_W-1:0] want,
                            input logic [PAGE_W-1:0] got);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
   endtask

   // response side: random stall bursts while idling is on
   always @(posedge clock) begin
      if (reset || !idling) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // every reply beat against the oldest reply still owed, field by field
   always @(posedge clock) begin : reply_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         if (reply_q.size() == 0) begin
            log_fault("unexpected reply", '0, rsp_data.result_page);
         end else begin
            want = reply_q.pop_front();
            if (rsp_data.status !== want.status)
               log_fault("status", PAGE_W'(want.status), PAGE_W'(rsp_data.status));
            if (rsp_data.result_page !== want.result_page)
               log_fault("result_page", want.result_page, rsp_data.result_page);
         end
      end
   end

   // hang detector: any beat on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no beat for %0d cycles, %0d replies outstanding",
                  $time, idle_cycles, reply_q.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // zero length on every action and the unused action code: ok, no change
   task automatic test_idle_requests();
      rsp_type reply;
      send_request(ACT_ALLOC, any_page(), '0, reply);
      send_request(ACT_FREE, any_page(), '0, reply);
      send_request(ACT_RESV, any_page(), '0, reply);
      send_request(ACT_NONE, any_page(), '0, reply);
      send_request(ACT_NONE, any_page(), any_page(), reply);
      send_request(ACT_NONE, '0, TOP_PAGE, reply);
   endtask

   // nothing free after reset
   task automatic test_empty_table();
      rsp_type reply;
      send_request(ACT_ALLOC, '0, PAGE_W'(1), reply);
      send_request(ACT_RESV, '0, PAGE_W'(1), reply);
      send_request(ACT_ALLOC, any_page(), TOP_PAGE, reply);
   endtask

   // frees at the top of the space, the whole space free, an allocate that
   // wraps its extent base back to page zero
   task automatic test_top_of_space();
      rsp_type reply;
      send_request(ACT_FREE, TOP_PAGE, PAGE_W'(1), reply);
      send_request(ACT_FREE, TOP_PAGE, PAGE_W'(2), reply);
      send_request(ACT_FREE, TOP_PAGE, TOP_PAGE, reply);
      send_request(ACT_FREE, '0, TOP_PAGE, reply);
      send_request(ACT_ALLOC, any_page(), TOP_PAGE, reply);
      send_request(ACT_ALLOC, any_page(), PAGE_W'(1), reply);
      send_request(ACT_ALLOC, '0, PAGE_W'(1), reply);
   endtask

   // reserve splits, whole-extent reserves, merges into a later empty slot
   task automatic test_split_and_merge();
      rsp_type reply;
      send_request(ACT_FREE, PAGE_W'(1000), PAGE_W'(100), reply);
      send_request(ACT_RESV, PAGE_W'(1010), PAGE_W'(20), reply);
      send_request(ACT_RESV, PAGE_W'(1030), PAGE_W'(70), reply);
      send_request(ACT_RESV, PAGE_W'(1000), PAGE_W'(10), reply);
      send_request(ACT_FREE, PAGE_W'(1020), PAGE_W'(10), reply);
      send_request(ACT_FREE, PAGE_W'(1000), PAGE_W'(20), reply);
      send_request(ACT_ALLOC, '0, PAGE_W'(30), reply);
      send_request(ACT_FREE, PAGE_W'(2000), PAGE_W'(10), reply);
      send_request(ACT_RESV, PAGE_W'(2000), PAGE_W'(4), reply);
      send_request(ACT_RESV, PAGE_W'(2008), PAGE_W'(4), reply);
   endtask

   // disjoint frees until no slot is left, then inserts and splits against a
   // full table, then allocate most of it back out and return part of that
   task automatic test_table_full();
      rsp_type           reply;
      logic [PAGE_W-1:0] cursor, len;
      logic [SUM_W-1:0]  span;
      int                tries, slot;
      cursor = {$urandom, 20'b0};
      tries = 0;
      reply.status = STS_OK;
      while (reply.status != STS_FULL && tries < 120) begin
         len = PAGE_W'($urandom_range(3, 6));
         send_request(ACT_FREE, cursor, len, reply);
         cursor = cursor + len + PAGE_W'($urandom_range(1, 3));
         tries++;
      end
      repeat (12) begin
         slot = $urandom_range(0, ext_count - 1);
         span = SUM_W'(ext_base[slot]) + SUM_W'(ext_size[slot]);
         case ($urandom_range(0, 3))
            0: send_request(ACT_FREE, cursor + PAGE_W'(5), PAGE_W'(1), reply);
            1: send_request(ACT_RESV, ext_base[slot] + PAGE_W'(1), PAGE_W'(1), reply);
            2: send_request(ACT_RESV, PAGE_W'(span - SUM_W'(1)), PAGE_W'(1), reply);
            default: send_request(ACT_FREE, PAGE_W'(span), PAGE_W'(1), reply);
         endcase
      end
      repeat (60) begin
         send_request(ACT_ALLOC, any_page(), PAGE_W'($urandom_range(1, 6)), reply);
         if (reply.status == STS_OK) begin
            held_page.push_back(reply.result_page);
            held_len.push_back(req_data.pages);
         end
      end
      repeat (30) begin
         if (held_page.size() != 0) begin
            slot = $urandom_range(0, held_page.size() - 1);
            send_request(ACT_FREE, held_page[slot], held_len[slot], reply);
            held_page.delete(slot);
            held_len.delete(slot);
         end
      end
   endtask

   // well-formed traffic in one window of the page space: allocates, frees of
   // what was handed out, loose frees, reserves inside known extents
   task automatic test_mixed_traffic(input int count, input bit with_gaps);
      rsp_type           reply;
      logic [PAGE_W-1:0] window, len;
      logic [SUM_W-1:0]  span;
      int                pick, slot, lim, offs;
      window = {$urandom, 20'b0};
      idling = with_gaps;
      repeat (count) begin
         // quiet stretches now and then even when gaps are allowed
         if (with_gaps && $urandom_range(0, 49) == 0) idling = !idling;
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            len = ($urandom_range(0, 9) == 0) ? PAGE_W'($urandom_range(1, 4096))
                                              : PAGE_W'($urandom_range(1, 16));
            send_request(ACT_ALLOC, any_page(), len, reply);
            if (reply.status == STS_OK) begin
               held_page.push_back(reply.result_page);
               held_len.push_back(len);
            end
         end else if (pick < 55 && held_page.size() != 0) begin
            slot = $urandom_range(0, held_page.size() - 1);
            send_request(ACT_FREE, held_page[slot], held_len[slot], reply);
            held_page.delete(slot);
            held_len.delete(slot);
         end else if (pick < 70) begin
            send_request(ACT_FREE, window + PAGE_W'($urandom_range(0, 2047)),
                         PAGE_W'($urandom_range(1, 32)), reply);
         end else if (pick < 90) begin
            slot = $urandom_range(0, ext_count - 1);
            if (ext_size[slot] == 0) begin
               send_request(ACT_RESV, window + PAGE_W'($urandom_range(0, 2047)),
                            PAGE_W'($urandom_range(1, 64)), reply);
            end else begin
               lim = (ext_size[slot] > 64) ? 64 : int'(ext_size[slot]);
               offs = $urandom_range(0, lim - 1);
               len = PAGE_W'($urandom_range(1, lim - offs));
               // from the front or counted back from the end of the extent
               if ($urandom_range(0, 1) == 0) begin
                  send_request(ACT_RESV, ext_base[slot] + PAGE_W'(offs), len, reply);
               end else begin
                  span = SUM_W'(ext_base[slot]) + SUM_W'(ext_size[slot]) - SUM_W'(offs)
                         - SUM_W'(len);
                  send_request(ACT_RESV, PAGE_W'(span), len, reply);
               end
            end
         end else begin
            send_request(ACT_RESV, window + PAGE_W'($urandom_range(0, 2047)),
                         PAGE_W'($urandom_range(1, 64)), reply);
         end
      end
      idling = 1'b0;
   endtask

   // any action code, any page, lengths from zero up to the full field
   task automatic test_noise(input int count);
      rsp_type           reply;
      logic [PAGE_W-1:0] page, len;
      idling = 1'b1;
      repeat (count) begin
         page = ($urandom_range(0, 3) == 0) ? (TOP_PAGE - PAGE_W'($urandom_range(0, 63)))
                                            : any_page();
         case ($urandom_range(0, 4))
            0: len = any_page();
            1: len = PAGE_W'($urandom);
            2: len = PAGE_W'($urandom_range(1, 8));
            3: len = TOP_PAGE - PAGE_W'($urandom_range(0, 15));
            default: len = ($urandom_range(0, 3) == 0) ? '0 : PAGE_W'($urandom_range(1, 1024));
         endcase
         send_request(2'($urandom_range(0, 3)), page, len, reply);
      end
      idling = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < FFEA_ENTRIES; i++) begin
         ext_base[i] = '0;
         ext_size[i] = '0;
      end
      ext_count = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_requests();
      test_empty_table();
      test_top_of_space();
      test_split_and_merge();
      test_table_full();
      test_mixed_traffic(650, 1'b1);
      test_noise(250);
      // last stretch back to back: no gaps and no stalls
      test_mixed_traffic(400, 1'b0);

      req_valid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests (allocate, free, reserve, unused code), %0d replies checked",
               sent_count, checked_count);
      $display("replies by status: ok %0d, no fit %0d, not found %0d, table full %0d",
               by_status[STS_OK], by_status[STS_NOFIT], by_status[STS_NOTFOUND],
               by_status[STS_FULL]);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches in total", fault_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
